// File: src/ipt_pkg.sv
package ipt_pkg;

    localparam int PosW  = 32;
    localparam int AngW  = 16;
    localparam int DiffW = PosW + 1;
    localparam int XW    = 34;
    localparam int ZW    = 21;
    localparam int Q24W  = 26;
    localparam int RW    = Q24W + 1;
    localparam int CordicSteps = 16;

    localparam logic signed [ZW-1:0] PiQ16     = ZW'(205887);
    localparam logic signed [ZW-1:0] TwoPiQ16  = ZW'(411775);
    localparam logic signed [ZW-1:0] HalfPiQ16 = ZW'(102944);
    localparam logic signed [XW-1:0] GainQ30   = XW'(652032874);
    localparam logic signed [Q24W-1:0] OneQ24  = Q24W'(16777216);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } lane_t;

    typedef struct packed {
        lane_t [2:0]            lane;
        logic  [2:0][DiffW-1:0] d;
    } cell_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(51472);
            1:       v = ZW'(30386);
            2:       v = ZW'(16055);
            3:       v = ZW'(8150);
            4:       v = ZW'(4091);
            5:       v = ZW'(2047);
            6:       v = ZW'(1024);
            7:       v = ZW'(512);
            8:       v = ZW'(256);
            9:       v = ZW'(128);
            10:      v = ZW'(64);
            11:      v = ZW'(32);
            12:      v = ZW'(16);
            13:      v = ZW'(8);
            14:      v = ZW'(4);
            15:      v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

    // product of two Q24 values, rounded back to Q24
    function automatic logic signed [Q24W-1:0] mul24(input logic signed [Q24W-1:0] a,
                                                      input logic signed [Q24W-1:0] b);
        logic signed [2*Q24W-1:0] p;
        p = a * b + (2*Q24W)'(64'sd8388608);
        return p[Q24W+23:24];
    endfunction

endpackage

// File: src/ipt_cordic_cell.sv
module ipt_cordic_cell
    import ipt_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  valid_i,
    input  cell_t data_i,
    output logic  valid_o,
    output cell_t data_o
);

    localparam logic signed [ZW-1:0] Atan = atan_q16(STEP);

    logic  valid_reg;
    cell_t data_reg, data_next;

    always_comb
    begin
        data_next = data_i;
        for (int k = 0; k < 3; k++)
        begin
            if (data_i.lane[k].z >= 0)
            begin
                data_next.lane[k].x = data_i.lane[k].x - (data_i.lane[k].y >>> STEP);
                data_next.lane[k].y = data_i.lane[k].y + (data_i.lane[k].x >>> STEP);
                data_next.lane[k].z = data_i.lane[k].z - Atan;
            end
            else
            begin
                data_next.lane[k].x = data_i.lane[k].x + (data_i.lane[k].y >>> STEP);
                data_next.lane[k].y = data_i.lane[k].y - (data_i.lane[k].x >>> STEP);
                data_next.lane[k].z = data_i.lane[k].z + Atan;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_i;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign valid_o = valid_reg;
    assign data_o  = data_reg;

endmodule

// File: src/ipt_rotation.sv
module ipt_rotation
    import ipt_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          valid_i,
    input  cell_t                         data_i,
    output logic                          valid_o,
    output logic signed [2:0][2:0][RW-1:0] r_o,
    output logic        [2:0][DiffW-1:0]   d_o
);

    // stage A: cosine/sine in Q24
    logic                         va_reg;
    logic signed [2:0][Q24W-1:0]  cs_reg, sn_reg, cs_next, sn_next;
    logic        [2:0][DiffW-1:0] da_reg;
    // stage B: first products
    logic                         vb_reg;
    logic signed [Q24W-1:0] ccsb_reg, scsb_reg, sc_ca_reg, sc_sa_reg, cc_ca_reg, cc_sa_reg;
    logic signed [Q24W-1:0] cccb_reg, sccb_reg, cbsa_reg, cbca_reg, sb_reg;
    logic signed [Q24W-1:0] sa_reg, ca_reg;
    logic        [2:0][DiffW-1:0] db_reg;
    // stage C: matrix
    logic                         vc_reg;
    logic signed [2:0][2:0][RW-1:0] r_reg, r_next;
    logic        [2:0][DiffW-1:0] dc_reg;

    always_comb
    begin
        logic signed [XW-1:0]  tx, ty;
        logic signed [XW-7:0]  qx, qy;
        logic signed [Q24W-1:0] cx, cy;
        for (int k = 0; k < 3; k++)
        begin
            tx = data_i.lane[k].x + XW'(32);
            ty = data_i.lane[k].y + XW'(32);
            qx = tx[XW-1:6];
            qy = ty[XW-1:6];
            if (qx > (XW-6)'(OneQ24))
                cx = OneQ24;
            else if (qx < -(XW-6)'(OneQ24))
                cx = -OneQ24;
            else
                cx = qx[Q24W-1:0];
            if (qy > (XW-6)'(OneQ24))
                cy = OneQ24;
            else if (qy < -(XW-6)'(OneQ24))
                cy = -OneQ24;
            else
                cy = qy[Q24W-1:0];
            cs_next[k] = data_i.lane[k].flip ? -cx : cx;
            sn_next[k] = data_i.lane[k].flip ? -cy : cy;
        end
    end

    // lane 0 roll (a), lane 1 pitch (b), lane 2 yaw (c)
    always_comb
    begin
        r_next[0][0] = RW'(cccb_reg);
        r_next[0][1] = RW'(mul24(ccsb_reg, sa_reg)) - RW'(sc_ca_reg);
        r_next[0][2] = RW'(mul24(ccsb_reg, ca_reg)) + RW'(sc_sa_reg);
        r_next[1][0] = RW'(sccb_reg);
        r_next[1][1] = RW'(mul24(scsb_reg, sa_reg)) + RW'(cc_ca_reg);
        r_next[1][2] = RW'(mul24(scsb_reg, ca_reg)) - RW'(cc_sa_reg);
        r_next[2][0] = -RW'(sb_reg);
        r_next[2][1] = RW'(cbsa_reg);
        r_next[2][2] = RW'(cbca_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= valid_i;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg    <= cs_next;
            sn_reg    <= sn_next;
            da_reg    <= data_i.d;
            ccsb_reg  <= mul24(cs_reg[2], sn_reg[1]);
            scsb_reg  <= mul24(sn_reg[2], sn_reg[1]);
            sc_ca_reg <= mul24(sn_reg[2], cs_reg[0]);
            sc_sa_reg <= mul24(sn_reg[2], sn_reg[0]);
            cc_ca_reg <= mul24(cs_reg[2], cs_reg[0]);
            cc_sa_reg <= mul24(cs_reg[2], sn_reg[0]);
            cccb_reg  <= mul24(cs_reg[2], cs_reg[1]);
            sccb_reg  <= mul24(sn_reg[2], cs_reg[1]);
            cbsa_reg  <= mul24(cs_reg[1], sn_reg[0]);
            cbca_reg  <= mul24(cs_reg[1], cs_reg[0]);
            sb_reg    <= sn_reg[1];
            sa_reg    <= sn_reg[0];
            ca_reg    <= cs_reg[0];
            db_reg    <= da_reg;
            r_reg     <= r_next;
            dc_reg    <= db_reg;
        end
    end

    assign valid_o = vc_reg;
    assign r_o     = r_reg;
    assign d_o     = dc_reg;

endmodule

// File: src/ipt_project.sv
module ipt_project
    import ipt_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           valid_i,
    input  logic signed [2:0][2:0][RW-1:0] r_i,
    input  logic        [2:0][DiffW-1:0]   d_i,
    output logic                           valid_o,
    output logic signed [2:0][PosW-1:0]    q_o
);

    localparam int PW = RW + DiffW;
    localparam int AW = PW + 2;

    logic                            vp_reg, vq_reg;
    logic signed [2:0][2:0][PW-1:0]  p_reg;
    logic signed [2:0][PosW-1:0]     q_reg, q_next;

    always_comb
    begin
        logic signed [AW-1:0]    acc;
        logic signed [AW-25:0]   s;
        for (int j = 0; j < 3; j++)
        begin
            acc = AW'($signed(p_reg[0][j])) + AW'($signed(p_reg[1][j]))
                + AW'($signed(p_reg[2][j])) + AW'(64'sd8388608);
            s   = acc[AW-1:24];
            if (s > (AW-24)'(64'sd2147483647))
                q_next[j] = {1'b0, {(PosW-1){1'b1}}};
            else if (s < -(AW-24)'(64'sd2147483648))
                q_next[j] = {1'b1, {(PosW-1){1'b0}}};
            else
                q_next[j] = s[PosW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= 1'b0;
            vq_reg <= 1'b0;
        end
        else if (en)
        begin
            vp_reg <= valid_i;
            vq_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    p_reg[k][j] <= PW'($signed(r_i[k][j]) * $signed(d_i[k]));
            q_reg <= q_next;
        end
    end

    assign valid_o = vq_reg;
    assign q_o     = q_reg;

endmodule

// File: src/inverse_pose_point_transform_core.sv
// channel | direction | handshake            | beat
// in      | input     | in_valid / in_stall  | point, pose, three angles
// out     | output    | out_valid / out_stall| local_x, local_y, local_z
//
// One beat in and one beat out per cycle while the pipe is not held; the pipe is
// the difference/angle wrap register, 16 CORDIC cells, 3 rotation stages and 2 projection stages.
// rst_n clears only the valid bits of the pipe.
// The whole pipe advances together; it holds while out_valid is high and out_stall
// is high, and in_stall is raised only then.
module inverse_pose_point_transform_core
    import ipt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [PosW-1:0] point_x,
    input  logic signed [PosW-1:0] point_y,
    input  logic signed [PosW-1:0] point_z,
    input  logic signed [PosW-1:0] pose_x,
    input  logic signed [PosW-1:0] pose_y,
    input  logic signed [PosW-1:0] pose_z,
    input  logic signed [AngW-1:0] angle_roll,
    input  logic signed [AngW-1:0] angle_pitch,
    input  logic signed [AngW-1:0] angle_yaw,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic signed [PosW-1:0] local_x,
    output logic signed [PosW-1:0] local_y,
    output logic signed [PosW-1:0] local_z
);

    logic en;
    logic  prep_valid_reg;
    cell_t prep_reg, prep_next;
    logic  [CordicSteps:0] cv;
    cell_t cd [CordicSteps+1];
    logic                           rot_valid;
    logic signed [2:0][2:0][RW-1:0] rot_r;
    logic        [2:0][DiffW-1:0]   rot_d;
    logic signed [2:0][PosW-1:0]    q;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        logic signed [AngW-1:0] ang [3];
        logic signed [ZW-1:0]   z;
        ang[0] = angle_roll;
        ang[1] = angle_pitch;
        ang[2] = angle_yaw;
        prep_next.d[0] = DiffW'(point_x) - DiffW'(pose_x);
        prep_next.d[1] = DiffW'(point_y) - DiffW'(pose_y);
        prep_next.d[2] = DiffW'(point_z) - DiffW'(pose_z);
        for (int k = 0; k < 3; k++)
        begin
            z = {{(ZW-AngW-3){ang[k][AngW-1]}}, ang[k], 3'b000};
            if (z > PiQ16)
                z = z - TwoPiQ16;
            if (z < -PiQ16)
                z = z + TwoPiQ16;
            prep_next.lane[k].flip = 1'b0;
            if (z > HalfPiQ16)
            begin
                z = z - PiQ16;
                prep_next.lane[k].flip = 1'b1;
            end
            else if (z < -HalfPiQ16)
            begin
                z = z + PiQ16;
                prep_next.lane[k].flip = 1'b1;
            end
            prep_next.lane[k].z = z;
            prep_next.lane[k].x = GainQ30;
            prep_next.lane[k].y = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    assign cv[0] = prep_valid_reg;
    assign cd[0] = prep_reg;

    for (genvar i = 0; i < CordicSteps; i++)
    begin : g_cell
        ipt_cordic_cell #(.STEP(i)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .valid_i (cv[i]),
            .data_i  (cd[i]),
            .valid_o (cv[i+1]),
            .data_o  (cd[i+1])
        );
    end

    ipt_rotation u_rot (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (cv[CordicSteps]),
        .data_i  (cd[CordicSteps]),
        .valid_o (rot_valid),
        .r_o     (rot_r),
        .d_o     (rot_d)
    );

    ipt_project u_proj (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .valid_i (rot_valid),
        .r_i     (rot_r),
        .d_i     (rot_d),
        .valid_o (out_valid),
        .q_o     (q)
    );

    assign local_x = q[0];
    assign local_y = q[1];
    assign local_z = q[2];

    // a held pipe keeps the occupancy of the angle wrap stage and every CORDIC cell
    a_hold_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(cv))
        else $error("cordic chain moved while held");

    // a result appears only from a beat in the projection stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(u_proj.vp_reg))
        else $error("result without source beat");

    // angle wrap leaves the roll lane within the CORDIC convergence range
    a_prep_range: assert property (@(posedge clk) disable iff (!rst_n)
        prep_valid_reg |-> (prep_reg.lane[0].z <= HalfPiQ16 && prep_reg.lane[0].z >= -HalfPiQ16))
        else $error("roll outside half-turn range");

endmodule
